// File: hdl/assert_macros.svh
// Assertion macros for the I2C master transaction engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define I2CM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("I2C master assertion failed");
`define I2CM_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("I2C master assertion failed");
`else
`define I2CM_ASSERT(label, clk, rst, prop)
`define I2CM_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hdl/i2cm_pkg.sv
// Types and constants shared by the I2C master transaction engine.
package i2cm_pkg;

   localparam int unsigned MaxTransfer = 256;
   localparam int unsigned CountWidth  = 9;
   localparam logic [8:0]  ShortDefault = 9'd16;
   localparam logic [3:0]  RetryReset   = 4'd5;

   typedef enum logic [1:0] {
      CMD_BEGIN      = 2'd0,
      CMD_WRITE_BYTE = 2'd1,
      CMD_TICK       = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] slave_byte;
      logic [7:0] sub_byte;
      logic       use_sub;
      logic       read_mode;
      logic [3:0] count_nibble;
      logic       long_count;
      logic [7:0] long_length;
      logic [7:0] data_byte;
      logic       scl_sense;
      logic       sda_sense;
   } req_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       byte_request;
      logic       busy_res;
      logic       done_res;
      logic       success;
   } rsp_type;

endpackage

// File: hdl/i2cm_req_reg.sv
// Input register that holds one request transaction until the core takes it.
module i2cm_req_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  i2cm_pkg::req_type req_item,
   input  logic              advance,
   output logic              req_stall,
   output logic              item_valid,
   output i2cm_pkg::req_type item
);

   logic              valid_ff;
   logic              valid_in;
   i2cm_pkg::req_type item_ff;
   logic              accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: hdl/i2cm_core.sv
// Bus sequencer: one step of the I2C transaction state machine per transaction.
`include "assert_macros.svh"
module i2cm_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  i2cm_pkg::req_type item,
   input  logic              csr_write,
   input  logic [3:0]        csr_data,
   output i2cm_pkg::rsp_type result
);

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_START_A   = 5'd1,
      PH_START_B   = 5'd2,
      PH_TX_LOW    = 5'd3,
      PH_TX_HIGH   = 5'd4,
      PH_ACK_LOW   = 5'd5,
      PH_ACK_HIGH  = 5'd6,
      PH_WAIT      = 5'd7,
      PH_RX_LOW    = 5'd8,
      PH_RX_HIGH   = 5'd9,
      PH_MACK_LOW  = 5'd10,
      PH_MACK_HIGH = 5'd11,
      PH_STOP_A    = 5'd12,
      PH_STOP_B    = 5'd13,
      PH_STOP_C    = 5'd14
   } phase_type;

   typedef enum logic [1:0] {
      STG_SLAVE = 2'd0,
      STG_SUB   = 2'd1,
      STG_DATA  = 2'd2
   } stage_type;

   localparam int unsigned CW = i2cm_pkg::CountWidth;

   phase_type     phase_ff, phase_in;
   logic [3:0]    bit_index_ff, bit_index_in;
   logic [7:0]    shift_ff, shift_in;
   logic [CW-1:0] bytes_left_ff, bytes_left_in;
   logic [CW-1:0] total_ff, total_in;
   logic [3:0]    attempts_ff, attempts_in;
   logic [7:0]    slave_ff, slave_in;
   logic [7:0]    sub_ff, sub_in;
   logic          use_sub_ff, use_sub_in;
   logic          read_mode_ff, read_mode_in;
   stage_type     stage_ff, stage_in;
   logic          ok_ff, ok_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic [3:0]    retry_ff, retry_in;

   logic [CW-1:0] n_long;
   logic [CW-1:0] n_short;
   logic [3:0]    bit_next;
   logic [CW-1:0] bytes_dec;
   logic [7:0]    rx_shift;
   logic [7:0]    rx_byte;
   logic          rx_valid;
   logic          done;
   logic          success;

   assign bit_next  = bit_index_ff + 4'd1;
   assign bytes_dec = bytes_left_ff - CW'(1);
   assign rx_shift  = {shift_ff[6:0], item.sda_sense};

   always_comb begin
      n_long = (item.long_length == 8'd0) ? CW'(i2cm_pkg::MaxTransfer)
                                          : CW'(item.long_length);
      if (n_long > CW'(i2cm_pkg::MaxTransfer)) begin
         n_long = CW'(i2cm_pkg::MaxTransfer);
      end
      n_short = (item.count_nibble == 4'd0) ? CW'(i2cm_pkg::ShortDefault)
                                            : CW'(item.count_nibble);
   end

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      bytes_left_in = bytes_left_ff;
      total_in      = total_ff;
      attempts_in   = attempts_ff;
      slave_in      = slave_ff;
      sub_in        = sub_ff;
      use_sub_in    = use_sub_ff;
      read_mode_in  = read_mode_ff;
      stage_in      = stage_ff;
      ok_in         = ok_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      retry_in      = csr_write ? csr_data : retry_ff;
      rx_byte       = 8'd0;
      rx_valid      = 1'b0;
      done          = 1'b0;
      success       = 1'b0;
      if (fire) begin
         case (i2cm_pkg::cmd_type'(item.command))
            i2cm_pkg::CMD_BEGIN: begin
               if (phase_ff == PH_IDLE) begin
                  slave_in      = item.slave_byte;
                  sub_in        = item.sub_byte;
                  use_sub_in    = item.use_sub;
                  read_mode_in  = item.read_mode;
                  total_in      = item.long_count ? n_long : n_short;
                  bytes_left_in = item.long_count ? n_long : n_short;
                  attempts_in   = retry_ff;
                  ok_in         = 1'b0;
                  phase_in      = PH_START_A;
               end
            end
            i2cm_pkg::CMD_WRITE_BYTE: begin
               if (phase_ff == PH_WAIT) begin
                  shift_in     = item.data_byte;
                  bit_index_in = 4'd0;
                  stage_in     = STG_DATA;
                  phase_in     = PH_TX_LOW;
               end
            end
            i2cm_pkg::CMD_TICK: begin
               case (phase_ff)
                  PH_IDLE: begin
                  end
                  PH_START_A: begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                     if (!item.scl_sense) begin
                        ok_in    = 1'b0;
                        phase_in = PH_STOP_A;
                     end else begin
                        phase_in = PH_START_B;
                     end
                  end
                  PH_START_B: begin
                     scl_in       = 1'b1;
                     sda_in       = 1'b0;
                     shift_in     = slave_ff;
                     bit_index_in = 4'd0;
                     stage_in     = STG_SLAVE;
                     phase_in     = PH_TX_LOW;
                  end
                  PH_TX_LOW: begin
                     scl_in   = 1'b0;
                     sda_in   = shift_ff[7];
                     phase_in = PH_TX_HIGH;
                  end
                  PH_TX_HIGH: begin
                     scl_in = 1'b1;
                     if (!item.scl_sense) begin
                        ok_in    = 1'b0;
                        phase_in = PH_STOP_A;
                     end else begin
                        shift_in     = {shift_ff[6:0], 1'b0};
                        bit_index_in = bit_next;
                        phase_in     = bit_next[3] ? PH_ACK_LOW : PH_TX_LOW;
                     end
                  end
                  PH_ACK_LOW: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = PH_ACK_HIGH;
                  end
                  PH_ACK_HIGH: begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                     if (!item.scl_sense || item.sda_sense) begin
                        ok_in    = 1'b0;
                        phase_in = PH_STOP_A;
                     end else if (stage_ff == STG_SLAVE && use_sub_ff) begin
                        shift_in     = sub_ff;
                        bit_index_in = 4'd0;
                        stage_in     = STG_SUB;
                        phase_in     = PH_TX_LOW;
                     end else if (stage_ff == STG_SLAVE || stage_ff == STG_SUB) begin
                        if (read_mode_ff) begin
                           shift_in     = 8'd0;
                           bit_index_in = 4'd0;
                           phase_in     = PH_RX_LOW;
                        end else begin
                           phase_in = PH_WAIT;
                        end
                     end else begin
                        bytes_left_in = bytes_dec;
                        if (bytes_dec == '0) begin
                           ok_in    = 1'b1;
                           phase_in = PH_STOP_A;
                        end else begin
                           phase_in = PH_WAIT;
                        end
                     end
                  end
                  PH_WAIT: begin
                     scl_in = 1'b0;
                  end
                  PH_RX_LOW: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     phase_in = PH_RX_HIGH;
                  end
                  PH_RX_HIGH: begin
                     scl_in       = 1'b1;
                     sda_in       = 1'b1;
                     shift_in     = rx_shift;
                     bit_index_in = bit_next;
                     if (bit_next[3]) begin
                        rx_byte  = rx_shift;
                        rx_valid = 1'b1;
                        phase_in = PH_MACK_LOW;
                     end else begin
                        phase_in = PH_RX_LOW;
                     end
                  end
                  PH_MACK_LOW: begin
                     scl_in   = 1'b0;
                     sda_in   = (bytes_left_ff == CW'(1));
                     phase_in = PH_MACK_HIGH;
                  end
                  PH_MACK_HIGH: begin
                     scl_in        = 1'b1;
                     bytes_left_in = bytes_dec;
                     if (bytes_dec == '0) begin
                        ok_in    = 1'b1;
                        phase_in = PH_STOP_A;
                     end else begin
                        shift_in     = 8'd0;
                        bit_index_in = 4'd0;
                        phase_in     = PH_RX_LOW;
                     end
                  end
                  PH_STOP_A: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = PH_STOP_B;
                  end
                  PH_STOP_B: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b0;
                     phase_in = PH_STOP_C;
                  end
                  PH_STOP_C: begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                     if (ok_ff) begin
                        done     = 1'b1;
                        success  = 1'b1;
                        phase_in = PH_IDLE;
                     end else if (attempts_ff != 4'd0) begin
                        attempts_in   = attempts_ff - 4'd1;
                        bytes_left_in = total_ff;
                        ok_in         = 1'b0;
                        phase_in      = PH_START_A;
                     end else begin
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.scl_drive    = scl_in;
      result.sda_drive    = sda_in;
      result.rx_byte      = rx_byte;
      result.rx_valid     = rx_valid;
      result.byte_request = (phase_in == PH_WAIT);
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.success      = success;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         bytes_left_ff <= '0;
         total_ff      <= '0;
         attempts_ff   <= 4'd0;
         slave_ff      <= 8'd0;
         sub_ff        <= 8'd0;
         use_sub_ff    <= 1'b0;
         read_mode_ff  <= 1'b0;
         stage_ff      <= STG_SLAVE;
         ok_ff         <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         retry_ff      <= i2cm_pkg::RetryReset;
      end else begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         bytes_left_ff <= bytes_left_in;
         total_ff      <= total_in;
         attempts_ff   <= attempts_in;
         slave_ff      <= slave_in;
         sub_ff        <= sub_in;
         use_sub_ff    <= use_sub_in;
         read_mode_ff  <= read_mode_in;
         stage_ff      <= stage_in;
         ok_ff         <= ok_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         retry_ff      <= retry_in;
      end
   end

   `I2CM_ASSERT(a_wait_only_on_write, clock, reset, (phase_ff == PH_WAIT) |-> !read_mode_ff)
   `I2CM_ASSERT(a_success_drained, clock, reset, (phase_ff == PH_STOP_C && ok_ff) |-> (bytes_left_ff == '0))
   `I2CM_ASSERT(a_done_to_idle, clock, reset, (fire && done) |=> (phase_ff == PH_IDLE))

endmodule

// File: hdl/i2cm_rsp_reg.sv
// Output register that holds one response transaction until it is taken.
module i2cm_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  i2cm_pkg::rsp_type in_item,
   input  logic              rsp_stall,
   output logic              in_ready,
   output logic              rsp_valid,
   output i2cm_pkg::rsp_type rsp_item
);

   logic              valid_ff;
   logic              valid_in;
   i2cm_pkg::rsp_type item_ff;
   logic              load;

   assign in_ready = ~valid_ff | ~rsp_stall;
   assign load     = in_valid & in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// File: hdl/i2c_master_transaction_engine.sv
// A request transaction is registered in the input register and its response in the output register.
// Throughput: one transaction per cycle while rsp_stall is low; one bus step of the sequencer per transaction.
// The input register and the output register each hold one transaction.
// Reset is synchronous and active high: idle, both lines released, retry_count 5.
// The configuration port is ready whenever no request transaction is held.
// Top level of the I2C master transaction engine.
module i2c_master_transaction_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_slave_byte,
   input  logic [7:0] req_sub_byte,
   input  logic       req_use_sub,
   input  logic       req_read_mode,
   input  logic [3:0] req_count_nibble,
   input  logic       req_long_count,
   input  logic [7:0] req_long_length,
   input  logic [7:0] req_data_byte,
   input  logic       req_scl_sense,
   input  logic       req_sda_sense,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_drive,
   output logic       rsp_sda_drive,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_rx_valid,
   output logic       rsp_byte_request,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_success,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_retry_count
);

   i2cm_pkg::req_type req_item;
   i2cm_pkg::req_type item;
   i2cm_pkg::rsp_type result;
   i2cm_pkg::rsp_type rsp_item;
   logic              item_valid;
   logic              advance;
   logic              out_ready;

   always_comb begin
      req_item.command      = req_command;
      req_item.slave_byte   = req_slave_byte;
      req_item.sub_byte     = req_sub_byte;
      req_item.use_sub      = req_use_sub;
      req_item.read_mode    = req_read_mode;
      req_item.count_nibble = req_count_nibble;
      req_item.long_count   = req_long_count;
      req_item.long_length  = req_long_length;
      req_item.data_byte    = req_data_byte;
      req_item.scl_sense    = req_scl_sense;
      req_item.sda_sense    = req_sda_sense;
   end

   assign advance   = item_valid & out_ready;
   assign csr_ready = ~item_valid;

   i2cm_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .advance    (advance),
      .req_stall  (req_stall),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_retry_count),
      .result    (result)
   );

   i2cm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_valid),
      .in_item   (result),
      .rsp_stall (rsp_stall),
      .in_ready  (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_scl_drive    = rsp_item.scl_drive;
   assign rsp_sda_drive    = rsp_item.sda_drive;
   assign rsp_rx_byte      = rsp_item.rx_byte;
   assign rsp_rx_valid     = rsp_item.rx_valid;
   assign rsp_byte_request = rsp_item.byte_request;
   assign rsp_busy_res     = rsp_item.busy_res;
   assign rsp_done_res     = rsp_item.done_res;
   assign rsp_success      = rsp_item.success;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the I2C master transaction engine.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      BUS_IDLE, BUS_START_A, BUS_START_B, BUS_TX_LOW, BUS_TX_HIGH, BUS_ACK_LOW,
      BUS_ACK_HIGH, BUS_WAIT, BUS_RX_LOW, BUS_RX_HIGH, BUS_MACK_LOW, BUS_MACK_HIGH,
      BUS_STOP_A, BUS_STOP_B, BUS_STOP_C
   } bus_phase_type;

   typedef enum logic [1:0] {SEND_SLAVE, SEND_SUB, SEND_DATA} send_stage_type;

   localparam logic [1:0] CmdUnused = 2'd3;
   localparam int WatchdogLimit = 1000;
   localparam int MaxPrinted = 100;
   localparam int ItemTarget = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   i2cm_pkg::req_type req_bits = '0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [3:0] csr_retry_count = 4'd0;
   bit no_idle = 1'b0;

   wire req_stall, rsp_valid, csr_ready;
   wire rsp_scl_drive, rsp_sda_drive, rsp_rx_valid, rsp_byte_request;
   wire rsp_busy_res, rsp_done_res, rsp_success;
   wire [7:0] rsp_rx_byte;

   // Engine state as the testbench predicts it.
   bus_phase_type bus_phase = BUS_IDLE;
   send_stage_type send_stage = SEND_SLAVE;
   logic [3:0] bit_cnt = '0;
   logic [7:0] shift_q = '0;
   logic [8:0] bytes_left = '0;
   logic [8:0] total_bytes = '0;
   logic [3:0] attempts_left = '0;
   logic [7:0] hdr_slave = '0;
   logic [7:0] hdr_sub = '0;
   logic hdr_use_sub = 1'b0;
   logic hdr_read = 1'b0;
   logic outcome_ok = 1'b0;
   logic scl_q = 1'b1;
   logic sda_q = 1'b1;
   logic [3:0] retry_cfg = i2cm_pkg::RetryReset;

   i2cm_pkg::rsp_type expected_outputs[$];
   int sent_items = 0;
   int errors = 0;
   int idle_cycles = 0;

   always #1 clock = ~clock;

   i2c_master_transaction_engine i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_bits.command),
      .req_slave_byte(req_bits.slave_byte),
      .req_sub_byte(req_bits.sub_byte),
      .req_use_sub(req_bits.use_sub),
      .req_read_mode(req_bits.read_mode),
      .req_count_nibble(req_bits.count_nibble),
      .req_long_count(req_bits.long_count),
      .req_long_length(req_bits.long_length),
      .req_data_byte(req_bits.data_byte),
      .req_scl_sense(req_bits.scl_sense),
      .req_sda_sense(req_bits.sda_sense),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_scl_drive(rsp_scl_drive),
      .rsp_sda_drive(rsp_sda_drive),
      .rsp_rx_byte(rsp_rx_byte),
      .rsp_rx_valid(rsp_rx_valid),
      .rsp_byte_request(rsp_byte_request),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_success(rsp_success),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_retry_count(csr_retry_count)
   );

   function automatic void start_attempt();
      bytes_left = total_bytes;
      outcome_ok = 1'b0;
      bus_phase = BUS_START_A;
   endfunction

   function automatic void abort_attempt();
      outcome_ok = 1'b0;
      bus_phase = BUS_STOP_A;
   endfunction

   function automatic void load_shift(input logic [7:0] value, input send_stage_type stg);
      shift_q = value;
      bit_cnt = 4'd0;
      send_stage = stg;
      bus_phase = BUS_TX_LOW;
   endfunction

   function automatic void enter_payload();
      if (hdr_read) begin
         shift_q = 8'd0;
         bit_cnt = 4'd0;
         bus_phase = BUS_RX_LOW;
      end else begin
         bus_phase = BUS_WAIT;
      end
   endfunction

   function automatic i2cm_pkg::rsp_type engine_step(input i2cm_pkg::req_type r);
      i2cm_pkg::rsp_type o;
      logic [8:0] n;
      o = '0;
      case (r.command)
         i2cm_pkg::CMD_BEGIN: begin
            if (bus_phase == BUS_IDLE) begin
               hdr_slave = r.slave_byte;
               hdr_sub = r.sub_byte;
               hdr_use_sub = r.use_sub;
               hdr_read = r.read_mode;
               if (r.long_count) begin
                  n = (r.long_length == 8'd0) ? 9'd256 : {1'b0, r.long_length};
                  if (n > i2cm_pkg::MaxTransfer) n = 9'(i2cm_pkg::MaxTransfer);
               end else begin
                  n = (r.count_nibble == 4'd0) ? i2cm_pkg::ShortDefault
                                               : {5'd0, r.count_nibble};
               end
               total_bytes = n;
               attempts_left = retry_cfg;
               start_attempt();
            end
         end
         i2cm_pkg::CMD_WRITE_BYTE: begin
            if (bus_phase == BUS_WAIT) begin
               load_shift(r.data_byte, SEND_DATA);
            end
         end
         i2cm_pkg::CMD_TICK: begin
            case (bus_phase)
               BUS_START_A: begin
                  scl_q = 1'b1;
                  sda_q = 1'b1;
                  if (!r.scl_sense) abort_attempt();
                  else bus_phase = BUS_START_B;
               end
               BUS_START_B: begin
                  scl_q = 1'b1;
                  sda_q = 1'b0;
                  load_shift(hdr_slave, SEND_SLAVE);
               end
               BUS_TX_LOW: begin
                  scl_q = 1'b0;
                  sda_q = shift_q[7];
                  bus_phase = BUS_TX_HIGH;
               end
               BUS_TX_HIGH: begin
                  scl_q = 1'b1;
                  if (!r.scl_sense) begin
                     abort_attempt();
                  end else begin
                     shift_q = shift_q << 1;
                     bit_cnt = bit_cnt + 4'd1;
                     bus_phase = (bit_cnt >= 4'd8) ? BUS_ACK_LOW : BUS_TX_LOW;
                  end
               end
               BUS_ACK_LOW: begin
                  scl_q = 1'b0;
                  sda_q = 1'b1;
                  bus_phase = BUS_ACK_HIGH;
               end
               BUS_ACK_HIGH: begin
                  scl_q = 1'b1;
                  sda_q = 1'b1;
                  if (!r.scl_sense || r.sda_sense) begin
                     abort_attempt();
                  end else if (send_stage == SEND_SLAVE) begin
                     if (hdr_use_sub) load_shift(hdr_sub, SEND_SUB);
                     else enter_payload();
                  end else if (send_stage == SEND_SUB) begin
                     enter_payload();
                  end else begin
                     bytes_left = bytes_left - 9'd1;
                     if (bytes_left == 9'd0) begin
                        outcome_ok = 1'b1;
                        bus_phase = BUS_STOP_A;
                     end else begin
                        bus_phase = BUS_WAIT;
                     end
                  end
               end
               BUS_WAIT: scl_q = 1'b0;
               BUS_RX_LOW: begin
                  scl_q = 1'b0;
                  sda_q = 1'b1;
                  bus_phase = BUS_RX_HIGH;
               end
               BUS_RX_HIGH: begin
                  scl_q = 1'b1;
                  sda_q = 1'b1;
                  shift_q = {shift_q[6:0], r.sda_sense};
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= 4'd8) begin
                     o.rx_byte = shift_q;
                     o.rx_valid = 1'b1;
                     bus_phase = BUS_MACK_LOW;
                  end else begin
                     bus_phase = BUS_RX_LOW;
                  end
               end
               BUS_MACK_LOW: begin
                  scl_q = 1'b0;
                  sda_q = (bytes_left == 9'd1);
                  bus_phase = BUS_MACK_HIGH;
               end
               BUS_MACK_HIGH: begin
                  scl_q = 1'b1;
                  bytes_left = bytes_left - 9'd1;
                  if (bytes_left == 9'd0) begin
                     outcome_ok = 1'b1;
                     bus_phase = BUS_STOP_A;
                  end else begin
                     shift_q = 8'd0;
                     bit_cnt = 4'd0;
                     bus_phase = BUS_RX_LOW;
                  end
               end
               BUS_STOP_A: begin
                  scl_q = 1'b0;
                  sda_q = 1'b0;
                  bus_phase = BUS_STOP_B;
               end
               BUS_STOP_B: begin
                  scl_q = 1'b1;
                  sda_q = 1'b0;
                  bus_phase = BUS_STOP_C;
               end
               BUS_STOP_C: begin
                  scl_q = 1'b1;
                  sda_q = 1'b1;
                  if (outcome_ok) begin
                     o.done_res = 1'b1;
                     o.success = 1'b1;
                     bus_phase = BUS_IDLE;
                  end else if (attempts_left != 4'd0) begin
                     attempts_left = attempts_left - 4'd1;
                     start_attempt();
                  end else begin
                     o.done_res = 1'b1;
                     bus_phase = BUS_IDLE;
                  end
               end
               default: bus_phase = BUS_IDLE;
            endcase
         end
         default: ;
      endcase
      o.scl_drive = scl_q;
      o.sda_drive = sda_q;
      o.byte_request = (bus_phase == BUS_WAIT);
      o.busy_res = (bus_phase != BUS_IDLE);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < MaxPrinted)
         $display("mismatch in %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
      errors++;
   endtask

   function automatic i2cm_pkg::req_type random_req();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(i2cm_pkg::req_type)-1:0];
   endfunction

   function automatic i2cm_pkg::req_type make_header(input logic [7:0] slave,
                                                     input logic [7:0] sub,
                                                     input logic use_sub,
                                                     input logic read_mode,
                                                     input logic long_count,
                                                     input logic [3:0] nibble,
                                                     input logic [7:0] len);
      i2cm_pkg::req_type r;
      r = random_req();
      r.command = i2cm_pkg::CMD_BEGIN;
      r.slave_byte = slave;
      r.sub_byte = sub;
      r.use_sub = use_sub;
      r.read_mode = read_mode;
      r.long_count = long_count;
      r.count_nibble = nibble;
      r.long_length = len;
      return r;
   endfunction

   task automatic send_req(input i2cm_pkg::req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_bits <= r;
      do @(posedge clock); while (req_stall);
      sent_items++;
      expected_outputs.push_back(engine_step(r));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_retry_count(input logic [3:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_retry_count <= value;
      do @(posedge clock); while (!csr_ready);
      retry_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Plays the slave side: supplies write bytes when asked and answers each bus step.
   task automatic bus_slave_step(input int nack_pct, input int fault_pct);
      i2cm_pkg::req_type r;
      r = random_req();
      if (bus_phase == BUS_WAIT && $urandom_range(0, 7) != 0) begin
         r.command = i2cm_pkg::CMD_WRITE_BYTE;
      end else begin
         r.command = i2cm_pkg::CMD_TICK;
         r.scl_sense = ($urandom_range(0, 99) >= fault_pct);
         if (bus_phase == BUS_ACK_HIGH) r.sda_sense = ($urandom_range(0, 99) < nack_pct);
      end
      if ($urandom_range(0, 29) == 0) r.command = 2'($urandom_range(0, 3));
      send_req(r);
   endtask

   task automatic run_transfer(input i2cm_pkg::req_type hdr, input int nack_pct,
                               input int fault_pct);
      hdr.command = i2cm_pkg::CMD_BEGIN;
      send_req(hdr);
      while (bus_phase != BUS_IDLE) bus_slave_step(nack_pct, fault_pct);
   endtask

   task automatic test_idle_commands();
      i2cm_pkg::req_type r;
      r = random_req();
      r.command = i2cm_pkg::CMD_TICK;
      send_req(r);
      r = random_req();
      r.command = CmdUnused;
      send_req(r);
      r = random_req();
      r.command = i2cm_pkg::CMD_WRITE_BYTE;
      send_req(r);
   endtask

   task automatic test_write_transfers();
      run_transfer(make_header(8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 4'd2, 8'hFF), 0, 0);
      run_transfer(make_header(8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 4'd1, 8'h00), 0, 0);
   endtask

   task automatic test_read_transfers();
      run_transfer(make_header(8'hA1, 8'h5A, 1'b0, 1'b1, 1'b0, 4'd0, 8'h00), 0, 0);
   endtask

   task automatic test_retries();
      write_retry_count(4'd0);
      run_transfer(make_header(8'h42, 8'h10, 1'b1, 1'b0, 1'b0, 4'd1, 8'h00), 100, 0);
      write_retry_count(4'd15);
      run_transfer(make_header(8'h42, 8'h10, 1'b1, 1'b0, 1'b0, 4'd1, 8'h00), 30, 0);
      write_retry_count(4'd3);
      run_transfer(make_header(8'h43, 8'h20, 1'b1, 1'b1, 1'b0, 4'd1, 8'h00), 0, 40);
   endtask

   task automatic test_long_counts();
      write_retry_count(4'd5);
      run_transfer(make_header(8'h91, 8'h00, 1'b0, 1'b1, 1'b1, 4'd0, 8'h02), 0, 0);
      write_retry_count(4'd0);
      run_transfer(make_header(8'h90, 8'h33, 1'b1, 1'b0, 1'b1, 4'd15, 8'h00), 100, 0);
   endtask

   task automatic test_random_traffic();
      int nack_pct;
      int fault_pct;
      i2cm_pkg::req_type hdr;
      while (sent_items < ItemTarget) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: write_retry_count(4'd0);
               1: write_retry_count(4'd15);
               default: write_retry_count(4'($urandom_range(0, 15)));
            endcase
         end
         no_idle = ($urandom_range(0, 4) == 0);
         hdr = random_req();
         hdr.count_nibble = 4'($urandom_range(1, 3));
         if ($urandom_range(0, 9) != 0) hdr.long_count = 1'b0;
         else hdr.long_length = 8'($urandom_range(1, 4));
         case ($urandom_range(0, 3))
            0: nack_pct = 5;
            1: nack_pct = 20;
            default: nack_pct = 0;
         endcase
         fault_pct = ($urandom_range(0, 2) == 0) ? 2 : 0;
         run_transfer(hdr, nack_pct, fault_pct);
      end
      no_idle = 1'b0;
   endtask

   always begin : rsp_backpressure
      int hold;
      hold = no_idle ? 0 : $urandom_range(0, 7);
      repeat (hold) begin
         @(negedge clock);
         rsp_stall <= 1'b1;
      end
      @(negedge clock);
      rsp_stall <= 1'b0;
      do @(posedge clock); while (!(rsp_valid && !rsp_stall));
   end

   always @(posedge clock) begin : response_check
      i2cm_pkg::rsp_type got;
      i2cm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_scl_drive, rsp_sda_drive, rsp_rx_byte, rsp_rx_valid, rsp_byte_request,
                rsp_busy_res, rsp_done_res, rsp_success};
         if (expected_outputs.size() == 0) begin
            report_mismatch("unexpected response", 32'(got), 32'd0);
         end else begin
            want = expected_outputs.pop_front();
            if (got.scl_drive !== want.scl_drive)
               report_mismatch("scl_drive", 32'(got.scl_drive), 32'(want.scl_drive));
            if (got.sda_drive !== want.sda_drive)
               report_mismatch("sda_drive", 32'(got.sda_drive), 32'(want.sda_drive));
            if (got.rx_byte !== want.rx_byte)
               report_mismatch("rx_byte", 32'(got.rx_byte), 32'(want.rx_byte));
            if (got.rx_valid !== want.rx_valid)
               report_mismatch("rx_valid", 32'(got.rx_valid), 32'(want.rx_valid));
            if (got.byte_request !== want.byte_request)
               report_mismatch("byte_request", 32'(got.byte_request),
                               32'(want.byte_request));
            if (got.busy_res !== want.busy_res)
               report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
            if (got.done_res !== want.done_res)
               report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.success !== want.success)
               report_mismatch("success", 32'(got.success), 32'(want.success));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_commands();
      test_write_transfers();
      test_read_transfers();
      test_retries();
      test_long_counts();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_req_reg.sv
hdl/i2cm_core.sv
hdl/i2cm_rsp_reg.sv
hdl/i2c_master_transaction_engine.sv
tb/tb.sv
